@@ src/bounded_positional_list_assert.svh @@
// Assertion macros for the bounded positional list RTL.
// Expects signals named clk and rst_n in the including module.
`ifndef BOUNDED_POSITIONAL_LIST_ASSERT_SVH
`define BOUNDED_POSITIONAL_LIST_ASSERT_SVH

`define BPL_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

`define BPL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ src/bpl_pkg.sv @@
// Shared constants and types for the bounded positional list.
// No dependencies.
package bpl_pkg;

    localparam int CAPACITY_DEF = 32;

    localparam logic [2:0] KIND_INS_FRONT = 3'd0;
    localparam logic [2:0] KIND_INS_BACK  = 3'd1;
    localparam logic [2:0] KIND_INS_AT    = 3'd2;
    localparam logic [2:0] KIND_DEL_FRONT = 3'd3;
    localparam logic [2:0] KIND_DEL_BACK  = 3'd4;
    localparam logic [2:0] KIND_DEL_AT    = 3'd5;
    localparam logic [2:0] KIND_SEARCH    = 3'd6;
    localparam logic [2:0] KIND_NONE      = 3'd7;

    localparam logic [2:0] ST_DONE     = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_BADPOS   = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_FOUND    = 3'd4;
    localparam logic [2:0] ST_NOTFOUND = 3'd5;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_RESP  = 13'b0000000000010,
        S_INSF  = 13'b0000000000100,
        S_WRD   = 13'b0000000001000,
        S_WCHK  = 13'b0000000010000,
        S_IA1   = 13'b0000000100000,
        S_IA2   = 13'b0000001000000,
        S_DPRD  = 13'b0000010000000,
        S_DPWR  = 13'b0000100000000,
        S_DLFIN = 13'b0001000000000,
        S_SRD   = 13'b0010000000000,
        S_SCHK  = 13'b0100000000000,
        S_SEND  = 13'b1000000000000
    } state_t;

endpackage

@@ src/bounded_positional_list.sv @@
// Top level of the bounded positional list: sequencer, slot memories, output register.
// Depends on bpl_pkg, bpl_ram, bpl_alloc and bounded_positional_list_assert.svh.
//
// Channel  Dir  Fields (low bit up)
// s_*      in   tuser: kind[2:0]; tdata: item_value[31:0], position[39:32]
// m_*      out  tdata: status[2:0], result_value[34:3], match_position[41:35]; tlast = last
//
// Front inserts link a free slot in at the head; back inserts and inserts at position p
// (p >= 2) read the tail or walk from the head to item p-1, then link the slot in;
// deletes walk to the item and unlink it; searches visit every item; rejections only respond.
// Reset clears head, tail and length and marks every slot free at once; no clearing pass.
// Input is taken only when the sequencer is idle; a result waiting in the output
// register does not block the next transfer until a new result must be loaded.
`include "bounded_positional_list_assert.svh"

module bounded_positional_list #(
    parameter int CAPACITY = bpl_pkg::CAPACITY_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // item_value, position
    input  logic [2:0]  s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // status, result_value, match_position
    output logic        m_tlast
);

    localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int AW = 32 + SW;

    bpl_pkg::state_t state_reg, state_next;
    logic [SW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [LW-1:0] len_reg, len_next;
    logic [CAPACITY-1:0] map_reg, map_next;
    logic [2:0] kind_reg, kind_next;
    logic [31:0] val_reg, val_next;
    logic [SW-1:0] cur_reg, cur_next;
    logic [LW-1:0] cnt_reg, cnt_next, tgt_reg, tgt_next;
    logic [31:0] tval_reg, tval_next;
    logic [SW-1:0] tn_reg, tn_next, tp_reg, tp_next;
    logic pend_reg, pend_next;
    logic [LW-1:0] ppos_reg, ppos_next;
    logic [2:0] rst_reg, rst_next;
    logic [31:0] rval_reg, rval_next;
    logic mv_reg;
    logic [2:0] mstat_reg;
    logic [31:0] mval_reg;
    logic [6:0] mpos_reg;
    logic mlast_reg;

    logic push;
    logic [2:0] push_stat;
    logic [31:0] push_val;
    logic [6:0] push_pos;
    logic push_last;
    logic out_free;

    logic a_we, b_we;
    logic [SW-1:0] a_waddr, a_raddr, b_waddr, b_raddr, b_wdata, b_rdata;
    logic [AW-1:0] a_wdata, a_rdata;
    logic [31:0] a_val;
    logic [SW-1:0] a_next;
    logic [SW-1:0] free_idx;

    logic [2:0] in_kind;
    logic [31:0] in_val;
    logic [7:0] in_pos;
    logic [8:0] pos9, len9;
    logic full, accept, match;

    assign in_kind = s_tuser;
    assign in_val  = s_tdata[31:0];
    assign in_pos  = s_tdata[39:32];
    assign pos9 = {1'b0, in_pos};
    assign len9 = 9'(len_reg);
    assign full = (len_reg == LW'(CAPACITY));
    assign s_tready = (state_reg == bpl_pkg::S_IDLE);
    assign accept = s_tvalid && s_tready;
    assign out_free = !mv_reg || m_tready;
    assign a_val = a_rdata[31:0];
    assign a_next = a_rdata[32 +: SW];
    assign match = (a_val == val_reg);

    bpl_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_val_next_ram (
        .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
        .raddr(a_raddr), .rdata(a_rdata)
    );

    bpl_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_prev_ram (
        .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
        .raddr(b_raddr), .rdata(b_rdata)
    );

    bpl_alloc #(.CAPACITY(CAPACITY), .SW(SW)) u_alloc (
        .free_map(map_reg), .free_idx(free_idx)
    );

    always_comb
    begin
        state_next = state_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        len_next = len_reg;
        map_next = map_reg;
        kind_next = kind_reg;
        val_next = val_reg;
        cur_next = cur_reg;
        cnt_next = cnt_reg;
        tgt_next = tgt_reg;
        tval_next = tval_reg;
        tn_next = tn_reg;
        tp_next = tp_reg;
        pend_next = pend_reg;
        ppos_next = ppos_reg;
        rst_next = rst_reg;
        rval_next = rval_reg;
        push = 1'b0;
        push_stat = bpl_pkg::ST_DONE;
        push_val = '0;
        push_pos = '0;
        push_last = 1'b1;
        a_we = 1'b0;
        a_waddr = cur_reg;
        a_wdata = {tn_reg, tval_reg};
        a_raddr = cur_reg;
        b_we = 1'b0;
        b_waddr = cur_reg;
        b_wdata = cur_reg;
        b_raddr = cur_reg;

        unique case (state_reg)
            bpl_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    kind_next = in_kind;
                    val_next = in_val;
                    rval_next = '0;
                    rst_next = bpl_pkg::ST_DONE;
                    cnt_next = LW'(1);
                    tgt_next = LW'(1);
                    cur_next = head_reg;
                    unique case (in_kind) inside
                        bpl_pkg::KIND_INS_FRONT, bpl_pkg::KIND_INS_BACK:
                        begin
                            if (full)
                            begin
                                rst_next = bpl_pkg::ST_FULL;
                                state_next = bpl_pkg::S_RESP;
                            end
                            else if (in_kind == bpl_pkg::KIND_INS_FRONT || len_reg == '0)
                            begin
                                state_next = bpl_pkg::S_INSF;
                            end
                            else
                            begin
                                cur_next = tail_reg;
                                state_next = bpl_pkg::S_WRD;
                            end
                        end
                        bpl_pkg::KIND_INS_AT:
                        begin
                            if (in_pos == 8'd0 || pos9 > len9 + 9'd1)
                            begin
                                rst_next = bpl_pkg::ST_BADPOS;
                                state_next = bpl_pkg::S_RESP;
                            end
                            else if (full)
                            begin
                                rst_next = bpl_pkg::ST_FULL;
                                state_next = bpl_pkg::S_RESP;
                            end
                            else if (in_pos == 8'd1)
                            begin
                                state_next = bpl_pkg::S_INSF;
                            end
                            else
                            begin
                                tgt_next = LW'(in_pos - 8'd1);
                                state_next = bpl_pkg::S_WRD;
                            end
                        end
                        bpl_pkg::KIND_DEL_FRONT, bpl_pkg::KIND_DEL_BACK:
                        begin
                            if (len_reg == '0)
                            begin
                                rst_next = bpl_pkg::ST_EMPTY;
                                state_next = bpl_pkg::S_RESP;
                            end
                            else
                            begin
                                if (in_kind == bpl_pkg::KIND_DEL_BACK)
                                begin
                                    cur_next = tail_reg;
                                end
                                state_next = bpl_pkg::S_WRD;
                            end
                        end
                        bpl_pkg::KIND_DEL_AT:
                        begin
                            if (in_pos == 8'd0)
                            begin
                                rst_next = bpl_pkg::ST_BADPOS;
                                state_next = bpl_pkg::S_RESP;
                            end
                            else if (len_reg == '0)
                            begin
                                rst_next = bpl_pkg::ST_EMPTY;
                                state_next = bpl_pkg::S_RESP;
                            end
                            else if (pos9 > len9)
                            begin
                                rst_next = bpl_pkg::ST_BADPOS;
                                state_next = bpl_pkg::S_RESP;
                            end
                            else
                            begin
                                tgt_next = LW'(in_pos);
                                state_next = bpl_pkg::S_WRD;
                            end
                        end
                        bpl_pkg::KIND_SEARCH:
                        begin
                            pend_next = 1'b0;
                            if (len_reg == '0)
                            begin
                                rst_next = bpl_pkg::ST_NOTFOUND;
                                state_next = bpl_pkg::S_RESP;
                            end
                            else
                            begin
                                state_next = bpl_pkg::S_SRD;
                            end
                        end
                        default:
                        begin
                            state_next = bpl_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            bpl_pkg::S_RESP:
            begin
                if (out_free)
                begin
                    push = 1'b1;
                    push_stat = rst_reg;
                    push_val = rval_reg;
                    state_next = bpl_pkg::S_IDLE;
                end
            end
            bpl_pkg::S_INSF:
            begin
                a_we = 1'b1;
                a_waddr = free_idx;
                a_wdata = {head_reg, val_reg};
                if (len_reg != '0)
                begin
                    b_we = 1'b1;
                    b_waddr = head_reg;
                    b_wdata = free_idx;
                end
                else
                begin
                    tail_next = free_idx;
                end
                head_next = free_idx;
                map_next[free_idx] = 1'b0;
                len_next = len_reg + LW'(1);
                rst_next = bpl_pkg::ST_DONE;
                state_next = bpl_pkg::S_RESP;
            end
            bpl_pkg::S_WRD:
            begin
                state_next = bpl_pkg::S_WCHK;
            end
            bpl_pkg::S_WCHK:
            begin
                if (cnt_reg != tgt_reg)
                begin
                    cur_next = a_next;
                    a_raddr = a_next;
                    b_raddr = a_next;
                    cnt_next = cnt_reg + LW'(1);
                end
                else
                begin
                    tval_next = a_val;
                    tn_next = a_next;
                    tp_next = b_rdata;
                    if (kind_reg == bpl_pkg::KIND_INS_BACK || kind_reg == bpl_pkg::KIND_INS_AT)
                    begin
                        state_next = bpl_pkg::S_IA1;
                    end
                    else if (cur_reg == head_reg)
                    begin
                        head_next = a_next;
                        state_next = bpl_pkg::S_DLFIN;
                    end
                    else
                    begin
                        state_next = bpl_pkg::S_DPRD;
                    end
                end
            end
            bpl_pkg::S_IA1:
            begin
                a_we = 1'b1;
                a_waddr = cur_reg;
                a_wdata = {free_idx, tval_reg};
                b_we = 1'b1;
                b_waddr = free_idx;
                b_wdata = cur_reg;
                state_next = bpl_pkg::S_IA2;
            end
            bpl_pkg::S_IA2:
            begin
                a_we = 1'b1;
                a_waddr = free_idx;
                a_wdata = {tn_reg, val_reg};
                if (cur_reg == tail_reg)
                begin
                    tail_next = free_idx;
                end
                else
                begin
                    b_we = 1'b1;
                    b_waddr = tn_reg;
                    b_wdata = free_idx;
                end
                map_next[free_idx] = 1'b0;
                len_next = len_reg + LW'(1);
                rst_next = bpl_pkg::ST_DONE;
                state_next = bpl_pkg::S_RESP;
            end
            bpl_pkg::S_DPRD:
            begin
                a_raddr = tp_reg;
                state_next = bpl_pkg::S_DPWR;
            end
            bpl_pkg::S_DPWR:
            begin
                a_we = 1'b1;
                a_waddr = tp_reg;
                a_wdata = {tn_reg, a_val};
                state_next = bpl_pkg::S_DLFIN;
            end
            bpl_pkg::S_DLFIN:
            begin
                if (cur_reg != tail_reg)
                begin
                    b_we = 1'b1;
                    b_waddr = tn_reg;
                    b_wdata = tp_reg;
                end
                else
                begin
                    tail_next = tp_reg;
                end
                map_next[cur_reg] = 1'b1;
                len_next = len_reg - LW'(1);
                rst_next = bpl_pkg::ST_DONE;
                rval_next = tval_reg;
                state_next = bpl_pkg::S_RESP;
            end
            bpl_pkg::S_SRD:
            begin
                state_next = bpl_pkg::S_SCHK;
            end
            bpl_pkg::S_SCHK:
            begin
                if (!(match && pend_reg && !out_free))
                begin
                    if (match && pend_reg)
                    begin
                        push = 1'b1;
                        push_stat = bpl_pkg::ST_FOUND;
                        push_val = val_reg;
                        push_pos = 7'(ppos_reg);
                        push_last = 1'b0;
                    end
                    if (match)
                    begin
                        pend_next = 1'b1;
                        ppos_next = cnt_reg;
                    end
                    if (cnt_reg == len_reg)
                    begin
                        state_next = bpl_pkg::S_SEND;
                    end
                    else
                    begin
                        cur_next = a_next;
                        a_raddr = a_next;
                        cnt_next = cnt_reg + LW'(1);
                    end
                end
            end
            bpl_pkg::S_SEND:
            begin
                if (out_free)
                begin
                    push = 1'b1;
                    if (pend_reg)
                    begin
                        push_stat = bpl_pkg::ST_FOUND;
                        push_val = val_reg;
                        push_pos = 7'(ppos_reg);
                    end
                    else
                    begin
                        push_stat = bpl_pkg::ST_NOTFOUND;
                    end
                    state_next = bpl_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bpl_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bpl_pkg::S_IDLE;
            head_reg <= '0;
            tail_reg <= '0;
            len_reg <= '0;
            map_reg <= {CAPACITY{1'b1}};
            pend_reg <= 1'b0;
            mv_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            len_reg <= len_next;
            map_reg <= map_next;
            pend_reg <= pend_next;
            if (push)
            begin
                mv_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                mv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        val_reg <= val_next;
        cur_reg <= cur_next;
        cnt_reg <= cnt_next;
        tgt_reg <= tgt_next;
        tval_reg <= tval_next;
        tn_reg <= tn_next;
        tp_reg <= tp_next;
        ppos_reg <= ppos_next;
        rst_reg <= rst_next;
        rval_reg <= rval_next;
        if (push)
        begin
            mstat_reg <= push_stat;
            mval_reg <= push_val;
            mpos_reg <= push_pos;
            mlast_reg <= push_last;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata = {6'd0, mpos_reg, mval_reg, mstat_reg};
    assign m_tlast = mlast_reg;

    `BPL_ASSERT_ALWAYS(a_len_bound, len_reg <= LW'(CAPACITY))
    `BPL_ASSERT_ALWAYS(a_map_len, ($countones(map_reg) + int'(len_reg)) == CAPACITY)
    `BPL_ASSERT_NEXT(a_busy_after, accept && in_kind != bpl_pkg::KIND_NONE, state_reg != bpl_pkg::S_IDLE)

endmodule

@@ src/bpl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bpl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/bpl_alloc.sv @@
// Lowest free slot finder over the slot free map.
// No dependencies.
module bpl_alloc #(
    parameter int CAPACITY = 32,
    parameter int SW = 5
) (
    input  logic [CAPACITY-1:0] free_map,
    output logic [SW-1:0]       free_idx
);

    always_comb
    begin
        free_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (free_map[i])
            begin
                free_idx = SW'(i);
            end
        end
    end

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for bounded_positional_list: drives list operations over the
// stream input, predicts every result with a behavioral list model, and compares outputs.
// Depends on bpl_pkg and the bounded_positional_list RTL.
module tb;

    localparam int CAP = bpl_pkg::CAPACITY_DEF;
    localparam int HOLD_OFF_LEN = 400;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] value;
        logic [6:0]  mpos;
        logic        last;
    } list_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tlast;

    logic [31:0]  shadow_list[$];
    list_result_t pending_results[$];
    int           send_idle_pct;
    int           recv_idle_pct;
    int           hold_off_reqs;
    int           hold_off_served = 0;
    int           hold_left = 0;
    int           failures;
    int           transfers_in;
    int           transfers_out;
    int           searches_found;

    bounded_positional_list #(.CAPACITY(CAP)) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic list_result_t mk(logic [2:0] st, logic [31:0] v, logic [6:0] p,
                                        logic l);
        list_result_t r;
        r.status = st;
        r.value  = v;
        r.mpos   = p;
        r.last   = l;
        return r;
    endfunction

    // Apply one operation to the shadow list and queue the results it causes.
    task automatic predict_list_op(logic [2:0] kind, logic [31:0] v, logic [7:0] pos);
        int len;
        int hits;
        len = shadow_list.size();
        case (kind) inside
            bpl_pkg::KIND_INS_FRONT, bpl_pkg::KIND_INS_BACK:
            begin
                if (len >= CAP)
                    pending_results.push_back(mk(bpl_pkg::ST_FULL, 0, 0, 1));
                else
                begin
                    if (kind == bpl_pkg::KIND_INS_FRONT)
                        shadow_list.push_front(v);
                    else
                        shadow_list.push_back(v);
                    pending_results.push_back(mk(bpl_pkg::ST_DONE, 0, 0, 1));
                end
            end
            bpl_pkg::KIND_INS_AT:
            begin
                if (pos == 0 || pos > len + 1)
                    pending_results.push_back(mk(bpl_pkg::ST_BADPOS, 0, 0, 1));
                else if (len >= CAP)
                    pending_results.push_back(mk(bpl_pkg::ST_FULL, 0, 0, 1));
                else
                begin
                    shadow_list.insert(pos - 1, v);
                    pending_results.push_back(mk(bpl_pkg::ST_DONE, 0, 0, 1));
                end
            end
            bpl_pkg::KIND_DEL_FRONT, bpl_pkg::KIND_DEL_BACK:
            begin
                if (len == 0)
                    pending_results.push_back(mk(bpl_pkg::ST_EMPTY, 0, 0, 1));
                else if (kind == bpl_pkg::KIND_DEL_FRONT)
                    pending_results.push_back(mk(bpl_pkg::ST_DONE, shadow_list.pop_front(),
                                                 0, 1));
                else
                    pending_results.push_back(mk(bpl_pkg::ST_DONE, shadow_list.pop_back(),
                                                 0, 1));
            end
            bpl_pkg::KIND_DEL_AT:
            begin
                if (pos == 0)
                    pending_results.push_back(mk(bpl_pkg::ST_BADPOS, 0, 0, 1));
                else if (len == 0)
                    pending_results.push_back(mk(bpl_pkg::ST_EMPTY, 0, 0, 1));
                else if (pos > len)
                    pending_results.push_back(mk(bpl_pkg::ST_BADPOS, 0, 0, 1));
                else
                begin
                    pending_results.push_back(mk(bpl_pkg::ST_DONE, shadow_list[pos - 1], 0, 1));
                    shadow_list.delete(pos - 1);
                end
            end
            bpl_pkg::KIND_SEARCH:
            begin
                hits = 0;
                for (int i = 0; i < len; i++)
                begin
                    if (shadow_list[i] == v)
                    begin
                        pending_results.push_back(mk(bpl_pkg::ST_FOUND, v, 7'(i + 1), 0));
                        hits++;
                    end
                end
                if (hits == 0)
                    pending_results.push_back(mk(bpl_pkg::ST_NOTFOUND, 0, 0, 1));
                else
                begin
                    pending_results[pending_results.size() - 1].last = 1'b1;
                    searches_found++;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // Offer one item, hold until the transfer, then predict it.
    task automatic send_op(logic [2:0] kind, logic [31:0] v, logic [7:0] pos);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {pos, v};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_list_op(kind, v, pos);
        transfers_in++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_off_served != hold_off_reqs)
            begin
                hold_off_served <= hold_off_reqs;
                hold_left <= HOLD_OFF_LEN;
                m_tready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        list_result_t got;
        list_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = mk(m_tdata[2:0], m_tdata[34:3], m_tdata[41:35], m_tlast);
            transfers_out++;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transfer: status=%0d", got.status);
                failures++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    failures++;
                end
                if (got.value !== want.value)
                begin
                    $error("result_value: expected %0d, got %0d", $signed(want.value),
                           $signed(got.value));
                    failures++;
                end
                if (got.mpos !== want.mpos)
                begin
                    $error("match_position: expected %0d, got %0d", want.mpos, got.mpos);
                    failures++;
                end
                if (got.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, got.last);
                    failures++;
                end
            end
        end
    end

    task automatic test_directed();
        send_op(bpl_pkg::KIND_DEL_FRONT, 0, 0);
        send_op(bpl_pkg::KIND_DEL_BACK, 0, 0);
        send_op(bpl_pkg::KIND_DEL_AT, 0, 0);
        send_op(bpl_pkg::KIND_DEL_AT, 0, 1);
        send_op(bpl_pkg::KIND_SEARCH, 32'h5, 0);
        send_op(bpl_pkg::KIND_INS_AT, 32'h1, 0);
        send_op(bpl_pkg::KIND_INS_AT, 32'h1, 2);
        send_op(bpl_pkg::KIND_INS_AT, 32'h8000_0000, 1);
        send_op(bpl_pkg::KIND_INS_FRONT, 32'h7FFF_FFFF, 0);
        send_op(bpl_pkg::KIND_INS_BACK, 32'hFFFF_FFFF, 8'hFF);
        send_op(bpl_pkg::KIND_INS_AT, 32'h0, 4);
        send_op(bpl_pkg::KIND_INS_AT, 32'h7FFF_FFFF, 2);
        send_op(bpl_pkg::KIND_SEARCH, 32'h7FFF_FFFF, 0);
        send_op(bpl_pkg::KIND_DEL_AT, 0, 6);
        send_op(bpl_pkg::KIND_DEL_AT, 0, 8'hFF);
        send_op(bpl_pkg::KIND_DEL_AT, 0, 3);
        send_op(bpl_pkg::KIND_NONE, 32'h1234, 1);
        send_op(bpl_pkg::KIND_DEL_BACK, 0, 0);
        send_op(bpl_pkg::KIND_DEL_FRONT, 0, 0);
        send_op(bpl_pkg::KIND_SEARCH, 32'h0, 0);
    endtask

    // Fill to capacity under a long receiver hold-off, then probe the full cases.
    task automatic test_full_list();
        wait_drained();
        hold_off_reqs++;
        while (shadow_list.size() < CAP)
            send_op(bpl_pkg::KIND_INS_BACK, $urandom_range(3, 0), 0);
        send_op(bpl_pkg::KIND_INS_FRONT, 32'h9, 0);
        send_op(bpl_pkg::KIND_INS_BACK, 32'h9, 0);
        send_op(bpl_pkg::KIND_INS_AT, 32'h9, 8'(CAP));
        send_op(bpl_pkg::KIND_INS_AT, 32'h9, 8'(CAP + 2));
        send_op(bpl_pkg::KIND_SEARCH, 32'h2, 0);
        send_op(bpl_pkg::KIND_DEL_AT, 0, 8'(CAP));
        wait_drained();
    endtask

    task automatic test_random(int count);
        logic [2:0]  kind;
        logic [31:0] v;
        logic [7:0]  pos;
        int          len;
        for (int n = 0; n < count; n++)
        begin
            len  = shadow_list.size();
            kind = 3'($urandom_range(7, 0));
            if (len < 6 && $urandom_range(2, 0) != 0)
                kind = 3'($urandom_range(2, 0));
            if ($urandom_range(3, 0) != 0)
                v = $urandom_range(5, 0) - 2;
            else
                v = $urandom;
            case ($urandom_range(4, 0))
                0:       pos = 8'($urandom);
                1:       pos = 0;
                default: pos = 8'($urandom_range(len + 1, 1));
            endcase
            send_op(kind, v, pos);
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = '0;
        failures        = 0;
        transfers_in    = 0;
        transfers_out   = 0;
        searches_found  = 0;
        hold_off_reqs   = 0;
        send_idle_pct   = 17;
        recv_idle_pct   = 85;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_list();
        test_random(18);
        send_idle_pct = 85;
        recv_idle_pct = 17;
        test_random(18);
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(18);
        wait_drained();
        repeat (60) @(posedge clk);
        $display("Sent %0d items and checked %0d results, %0d searches with matches,",
                 transfers_in, transfers_out, searches_found);
        $display("covering empty, full and bad-position cases under three idle profiles.");
        if (failures == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("Some tests failed");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+src
src/bpl_pkg.sv
src/bpl_ram.sv
src/bpl_alloc.sv
src/bounded_positional_list.sv
dv/tb.sv
